[rtl/ps2_mouse_packet_tracker_defines.svh]
// Assertion helpers shared by the RTL.
// All of them sample on clk_i and are disabled while rst_ni is low.
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// Same-cycle implication
`define PS2MPT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ps2mpt: check failed");

// Next-cycle implication
`define PS2MPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2mpt: check failed");

`endif

[rtl/ps2mpt_pkg.sv]
`timescale 1ns / 1ps

package ps2mpt_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CURS_W  = 12;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned REG_IDX_W = 1;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  // Status byte: output full and auxiliary data must both be set
  localparam logic [BYTE_W-1:0] STATUS_NEED = 8'h21;

  // First packet byte layout
  localparam int unsigned BIT_LEFT   = 0;
  localparam int unsigned BIT_RIGHT  = 1;
  localparam int unsigned BIT_MIDDLE = 2;
  localparam int unsigned BIT_SYNC   = 3;

  // Packet byte position
  typedef logic [1:0] byte_idx_t;
  localparam byte_idx_t IDX_FIRST  = 2'd0;
  localparam byte_idx_t IDX_SECOND = 2'd1;
  localparam byte_idx_t IDX_LAST   = 2'd2;

  // Redraw every third moving packet
  typedef logic [1:0] redraw_cnt_t;
  localparam redraw_cnt_t REDRAW_EVERY = 2'd3;

endpackage

[rtl/ps2mpt_in_if.sv]
`timescale 1ns / 1ps

// Input channel: one controller status/data word
interface ps2mpt_in_if;
  logic                            valid;
  logic                            ready;
  logic [ps2mpt_pkg::BYTE_W-1:0]   ctrl_status;
  logic [ps2mpt_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output ctrl_status, output data_byte, input ready);
  modport sink   (input valid, input ctrl_status, input data_byte, output ready);
endinterface

[rtl/ps2mpt_out_if.sv]
`timescale 1ns / 1ps

// Output channel: one decoded packet word
interface ps2mpt_out_if;
  logic                            valid;
  logic                            ready;
  logic [ps2mpt_pkg::CURS_W-1:0]   cursor_x;
  logic [ps2mpt_pkg::CURS_W-1:0]   cursor_y;
  logic                            btn_left;
  logic                            btn_right;
  logic                            btn_middle;
  logic                            moved;
  logic                            redraw;

  modport source (output valid, output cursor_x, output cursor_y, output btn_left,
                  output btn_right, output btn_middle, output moved, output redraw,
                  input ready);
  modport sink   (input valid, input cursor_x, input cursor_y, input btn_left,
                  input btn_right, input btn_middle, input moved, input redraw,
                  output ready);
endinterface

[rtl/ps2_mouse_packet_tracker.sv]
// PS/2 mouse packet tracker.
// Output: a result word is valid in the cycle after the third byte of a packet is accepted.
// Throughput: one input word per cycle; the output register is the only stall point, and
//   words that do not complete a packet are taken even while a result waits.
// Reset (rst_ni low, async): byte position, cursor, redraw count and output valid clear;
//   screen size returns to 1024 x 768.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2_mouse_packet_tracker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ps2mpt_in_if.sink                           in_i,
  ps2mpt_out_if.source                        out_o,
  input  logic                                cfg_we_i,
  input  logic [ps2mpt_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ps2mpt_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned SW = (COORD_BITS + 1 > ps2mpt_pkg::CFG_W) ?
                               COORD_BITS + 1 : ps2mpt_pkg::CFG_W;
  localparam int unsigned XW = (COORD_BITS > ps2mpt_pkg::CURS_W) ?
                               COORD_BITS : ps2mpt_pkg::CURS_W;
  localparam int unsigned VW = COORD_BITS + 2;

  // Largest coordinate for a screen size: size-1, size 0 taken as 1, size capped at 2^COORD_BITS
  function automatic logic [COORD_BITS-1:0] max_coord(input logic [ps2mpt_pkg::CFG_W-1:0] sz);
    logic [SW-1:0] wsz;
    logic [SW-1:0] cap;
    logic [SW-1:0] dec;
    wsz = SW'(sz);
    cap = SW'(1) << COORD_BITS;
    dec = wsz - SW'(1);
    if (wsz == '0) begin
      max_coord = '0;
    end else if (wsz > cap) begin
      max_coord = '1;
    end else begin
      max_coord = dec[COORD_BITS-1:0];
    end
  endfunction

  // pos + delta, clamped to [0, maxc]
  function automatic logic [COORD_BITS-1:0] clamp_axis(input logic [COORD_BITS-1:0] pos,
                                                       input logic signed [8:0] delta,
                                                       input logic [COORD_BITS-1:0] maxc);
    logic signed [VW-1:0] v;
    v = $signed({2'b00, pos}) + VW'(delta);
    if (v < 0) begin
      clamp_axis = '0;
    end else if (v[COORD_BITS:0] > {1'b0, maxc}) begin
      clamp_axis = maxc;
    end else begin
      clamp_axis = v[COORD_BITS-1:0];
    end
  endfunction

  // Configuration registers
  logic [ps2mpt_pkg::CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ps2mpt_pkg::SCREEN_WIDTH_RST;
      height_q <= ps2mpt_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ps2mpt_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        ps2mpt_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Tracker state
  ps2mpt_pkg::byte_idx_t        idx_q, idx_d;
  logic [ps2mpt_pkg::BYTE_W-1:0] first_q, second_q;
  logic [COORD_BITS-1:0]        pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  ps2mpt_pkg::redraw_cnt_t      rcnt_q, rcnt_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [ps2mpt_pkg::CURS_W-1:0] out_x_q, out_y_q;
  logic [2:0]                   out_btn_q;
  logic                         out_moved_q, out_redraw_q;

  // Word qualification and handshake
  logic byte_ok, completes, in_fire, out_fire, res_fire;
  assign byte_ok   = (in_i.ctrl_status & ps2mpt_pkg::STATUS_NEED) == ps2mpt_pkg::STATUS_NEED;
  assign completes = byte_ok && (idx_q == ps2mpt_pkg::IDX_LAST);
  assign in_i.ready = !out_valid_q || out_o.ready || !completes;
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_fire  = out_valid_q && out_o.ready;
  assign res_fire  = in_fire && completes;

  // Packet completion
  logic                   sync;
  logic signed [8:0]      dx, dy_neg;
  logic [COORD_BITS-1:0]  max_x, max_y;
  logic                   moved_d, redraw_d;
  ps2mpt_pkg::redraw_cnt_t rcnt_inc;
  logic [XW-1:0]          ext_x, ext_y;

  assign sync     = first_q[ps2mpt_pkg::BIT_SYNC];
  assign dx       = $signed({second_q[7], second_q});
  assign dy_neg   = 9'sd0 - $signed({in_i.data_byte[7], in_i.data_byte});
  assign max_x    = max_coord(width_q);
  assign max_y    = max_coord(height_q);
  assign rcnt_inc = rcnt_q + 2'd1;

  always_comb begin
    idx_d    = idx_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    rcnt_d   = rcnt_q;
    moved_d  = 1'b0;
    redraw_d = 1'b0;
    if (in_fire && byte_ok) begin
      case (idx_q)
        ps2mpt_pkg::IDX_FIRST:  idx_d = ps2mpt_pkg::IDX_SECOND;
        ps2mpt_pkg::IDX_SECOND: idx_d = ps2mpt_pkg::IDX_LAST;
        default: begin
          idx_d = ps2mpt_pkg::IDX_FIRST;
          if (sync) begin
            pos_x_d = clamp_axis(pos_x_q, dx, max_x);
            pos_y_d = clamp_axis(pos_y_q, dy_neg, max_y);
            moved_d = 1'b1;
            if (rcnt_inc >= ps2mpt_pkg::REDRAW_EVERY) begin
              rcnt_d   = '0;
              redraw_d = 1'b1;
            end else begin
              rcnt_d = rcnt_inc;
            end
          end
        end
      endcase
    end
  end

  assign ext_x = XW'(pos_x_d);
  assign ext_y = XW'(pos_y_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= ps2mpt_pkg::IDX_FIRST;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Packet bytes and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && byte_ok && idx_q == ps2mpt_pkg::IDX_FIRST) begin
      first_q <= in_i.data_byte;
    end
    if (in_fire && byte_ok && idx_q == ps2mpt_pkg::IDX_SECOND) begin
      second_q <= in_i.data_byte;
    end
    if (res_fire) begin
      out_x_q      <= ext_x[ps2mpt_pkg::CURS_W-1:0];
      out_y_q      <= ext_y[ps2mpt_pkg::CURS_W-1:0];
      out_btn_q    <= first_q[2:0];
      out_moved_q  <= moved_d;
      out_redraw_q <= redraw_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cursor_x   = out_x_q;
  assign out_o.cursor_y   = out_y_q;
  assign out_o.btn_left   = out_btn_q[ps2mpt_pkg::BIT_LEFT];
  assign out_o.btn_right  = out_btn_q[ps2mpt_pkg::BIT_RIGHT];
  assign out_o.btn_middle = out_btn_q[ps2mpt_pkg::BIT_MIDDLE];
  assign out_o.moved      = out_moved_q;
  assign out_o.redraw     = out_redraw_q;

  // Checks
  `PS2MPT_ASSERT_NEXT(a_result_after_last, res_fire, out_valid_q)
  `PS2MPT_ASSERT_NOW(a_no_overwrite, res_fire, !out_valid_q || out_o.ready)
  `PS2MPT_ASSERT_NOW(a_redraw_moved, out_valid_q && out_redraw_q, out_moved_q)
  `PS2MPT_ASSERT_NOW(a_counters_range, 1'b1,
                     idx_q != 2'd3 && rcnt_q != ps2mpt_pkg::REDRAW_EVERY)

endmodule

[tb/ps2_mouse_packet_tracker_test.sv]
`timescale 1ns / 1ps

module ps2_mouse_packet_tracker_test;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned RESET_LEN   = 7;
  localparam int unsigned IDLE_PCT    = 29;
  localparam int unsigned DRAIN_PAD   = 4;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_WORDS = 50;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One decoded packet word, same field order as the output channel
  typedef struct packed {
    logic [ps2mpt_pkg::CURS_W-1:0] cur_x;
    logic [ps2mpt_pkg::CURS_W-1:0] cur_y;
    logic                          left;
    logic                          right;
    logic                          middle;
    logic                          moved;
    logic                          redraw;
  } mouse_word_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                        kind;
    logic [ps2mpt_pkg::BYTE_W-1:0]    status;
    logic [ps2mpt_pkg::BYTE_W-1:0]    data;
    logic [ps2mpt_pkg::REG_IDX_W-1:0] reg_idx;
    logic [ps2mpt_pkg::CFG_W-1:0]     reg_val;
    bit                               typed;
    mouse_word_t                      want;
  } script_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [ps2mpt_pkg::REG_IDX_W-1:0] cfg_idx_i;
  logic [ps2mpt_pkg::CFG_W-1:0]     cfg_wdata_i;

  ps2mpt_in_if  in_bus ();
  ps2mpt_out_if out_bus ();

  ps2_mouse_packet_tracker #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Tracker state as the block should hold it
  ps2mpt_pkg::byte_idx_t         pkt_pos    = ps2mpt_pkg::IDX_FIRST;
  logic [ps2mpt_pkg::BYTE_W-1:0] pkt_first  = '0;
  logic [ps2mpt_pkg::BYTE_W-1:0] pkt_second = '0;
  logic [ps2mpt_pkg::CURS_W-1:0] pos_x      = '0;
  logic [ps2mpt_pkg::CURS_W-1:0] pos_y      = '0;
  logic [2:0]                    buttons    = '0;
  ps2mpt_pkg::redraw_cnt_t       moves_seen = '0;
  logic [ps2mpt_pkg::CFG_W-1:0]  scr_w      = ps2mpt_pkg::SCREEN_WIDTH_RST;
  logic [ps2mpt_pkg::CFG_W-1:0]  scr_h      = ps2mpt_pkg::SCREEN_HEIGHT_RST;

  mouse_word_t expected_words[$];
  script_row_t script[$];
  int unsigned mismatches   = 0;
  int unsigned words_seen   = 0;
  int unsigned cycles       = 0;
  int unsigned hold_left    = 0;
  bit          calm         = 1'b0;
  bit          hold_req     = 1'b0;

  function automatic logic [ps2mpt_pkg::CURS_W-1:0] clamp_coord(
      input logic [ps2mpt_pkg::CURS_W-1:0] pos,
      input int delta,
      input logic [ps2mpt_pkg::CFG_W-1:0] size);
    int lim;
    int v;
    lim = (size == '0) ? 1 : int'(size);
    if (lim > (1 << COORD_BITS)) lim = 1 << COORD_BITS;
    v = int'(pos) + delta;
    if (v < 0) v = 0;
    if (v >= lim) v = lim - 1;
    return v[ps2mpt_pkg::CURS_W-1:0];
  endfunction

  // Advance the tracker by one word; returns 1 when a packet completes
  function automatic bit track_byte(input logic [ps2mpt_pkg::BYTE_W-1:0] st,
                                    input logic [ps2mpt_pkg::BYTE_W-1:0] db,
                                    output mouse_word_t w);
    logic moved;
    logic redraw;
    w = '0;
    moved = 1'b0;
    redraw = 1'b0;
    if ((st & ps2mpt_pkg::STATUS_NEED) != ps2mpt_pkg::STATUS_NEED) return 1'b0;
    if (pkt_pos == ps2mpt_pkg::IDX_FIRST) begin
      pkt_first = db;
      pkt_pos = ps2mpt_pkg::IDX_SECOND;
      return 1'b0;
    end
    if (pkt_pos == ps2mpt_pkg::IDX_SECOND) begin
      pkt_second = db;
      pkt_pos = ps2mpt_pkg::IDX_LAST;
      return 1'b0;
    end
    pkt_pos = ps2mpt_pkg::IDX_FIRST;
    buttons = pkt_first[2:0];
    if (pkt_first[ps2mpt_pkg::BIT_SYNC]) begin
      // x adds dx, y subtracts dy
      pos_x = clamp_coord(pos_x, int'($signed(pkt_second)), scr_w);
      pos_y = clamp_coord(pos_y, -int'($signed(db)), scr_h);
      moved = 1'b1;
      moves_seen = moves_seen + 2'd1;
      if (moves_seen >= ps2mpt_pkg::REDRAW_EVERY) begin
        moves_seen = '0;
        redraw = 1'b1;
      end
    end
    w = {pos_x, pos_y, buttons[ps2mpt_pkg::BIT_LEFT], buttons[ps2mpt_pkg::BIT_RIGHT],
         buttons[ps2mpt_pkg::BIT_MIDDLE], moved, redraw};
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [ps2mpt_pkg::CURS_W-1:0] got,
                             input logic [ps2mpt_pkg::CURS_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("word %0d %s got 0x%0h want 0x%0h", words_seen, name, got,
                              want));
  endtask

  function automatic script_row_t word_row(input logic [ps2mpt_pkg::BYTE_W-1:0] st,
                                           input logic [ps2mpt_pkg::BYTE_W-1:0] db);
    script_row_t r;
    r = '{kind: ROW_WORD, status: st, data: db, reg_idx: '0, reg_val: '0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic script_row_t typed_row(input logic [ps2mpt_pkg::BYTE_W-1:0] st,
                                            input logic [ps2mpt_pkg::BYTE_W-1:0] db,
                                            input mouse_word_t want);
    script_row_t r;
    r = word_row(st, db);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic script_row_t reg_row(input logic [ps2mpt_pkg::REG_IDX_W-1:0] idx,
                                          input logic [ps2mpt_pkg::CFG_W-1:0] val);
    script_row_t r;
    r = word_row('0, '0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Directed script: screen starts at 1024 x 768, cursor at 0,0
  task automatic load_script();
    // status byte without both flags
    script.push_back(word_row(8'h00, 8'hFF));
    // sync, all buttons, no motion
    script.push_back(word_row(8'h21, 8'h0F));
    script.push_back(word_row(8'h21, 8'h00));
    script.push_back(typed_row(8'h21, 8'h00, {12'd0, 12'd0, 5'b11110}));
    // most negative dx, most positive dy: both clamp at 0
    script.push_back(word_row(8'hFF, 8'h08));
    script.push_back(word_row(8'hFF, 8'h80));
    script.push_back(typed_row(8'hFF, 8'h7F, {12'd0, 12'd0, 5'b00010}));
    // third moving packet redraws; words with one flag missing are dropped mid-packet
    script.push_back(word_row(8'h21, 8'h08));
    script.push_back(word_row(8'h20, 8'h08));
    script.push_back(word_row(8'h21, 8'h7F));
    script.push_back(word_row(8'h01, 8'h08));
    script.push_back(typed_row(8'h21, 8'h80, {12'd127, 12'd128, 5'b00011}));
    // sync clear: buttons only, cursor kept
    script.push_back(word_row(8'h21, 8'h05));
    script.push_back(word_row(8'h21, 8'h7F));
    script.push_back(typed_row(8'h21, 8'h7F, {12'd127, 12'd128, 5'b10100}));
    // zero screen size clamps both axes to 0
    script.push_back(reg_row(ps2mpt_pkg::REG_SCREEN_WIDTH, 13'd0));
    script.push_back(reg_row(ps2mpt_pkg::REG_SCREEN_HEIGHT, 13'd0));
    script.push_back(word_row(8'h21, 8'h08));
    script.push_back(word_row(8'h21, 8'h01));
    script.push_back(typed_row(8'h21, 8'hFF, {12'd0, 12'd0, 5'b00010}));
    // oversized screen saturates
    script.push_back(reg_row(ps2mpt_pkg::REG_SCREEN_WIDTH, 13'h1FFF));
    script.push_back(reg_row(ps2mpt_pkg::REG_SCREEN_HEIGHT, 13'h1FFF));
    script.push_back(word_row(8'h21, 8'h08));
    script.push_back(word_row(8'h21, 8'h7F));
    script.push_back(typed_row(8'h21, 8'h80, {12'd127, 12'd128, 5'b00010}));
    // shrink below the cursor: kept until the next moving packet
    script.push_back(reg_row(ps2mpt_pkg::REG_SCREEN_WIDTH, 13'd16));
    script.push_back(reg_row(ps2mpt_pkg::REG_SCREEN_HEIGHT, 13'd16));
    script.push_back(word_row(8'h21, 8'h00));
    script.push_back(word_row(8'h21, 8'h00));
    script.push_back(typed_row(8'h21, 8'h00, {12'd127, 12'd128, 5'b00000}));
    script.push_back(word_row(8'h21, 8'h08));
    script.push_back(word_row(8'h21, 8'h00));
    script.push_back(typed_row(8'h21, 8'h00, {12'd15, 12'd15, 5'b00011}));
  endtask

  // Offer one input word and wait for it to be taken
  task automatic offer_word(input logic [ps2mpt_pkg::BYTE_W-1:0] st,
                            input logic [ps2mpt_pkg::BYTE_W-1:0] db,
                            input bit typed, input mouse_word_t want);
    mouse_word_t w;
    bit          done;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid       <= 1'b0;
      in_bus.ctrl_status <= 8'($urandom);
      in_bus.data_byte   <= 8'($urandom);
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.ctrl_status <= st;
    in_bus.data_byte   <= db;
    do @(posedge clk_i); while (!in_bus.ready);
    done = track_byte(st, db, w);
    if (done) expected_words.push_back(typed ? want : w);
  endtask

  // Let every pending result out, plus a few idle cycles
  task automatic drain_block();
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ps2mpt_pkg::REG_IDX_W-1:0] idx,
                           input logic [ps2mpt_pkg::CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ps2mpt_pkg::REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
    @(posedge clk_i);
  endtask

  function automatic logic [ps2mpt_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'h1FFF;
      4: return 13'd4095;
      5, 6: return 13'($urandom_range(2, 64));
      default: return 13'($urandom_range(1, 8191));
    endcase
  endfunction

  function automatic logic [ps2mpt_pkg::BYTE_W-1:0] pick_delta();
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(0, 5))
        0: return 8'h7F;
        1: return 8'h80;
        2: return 8'h81;
        3: return 8'hFF;
        4: return 8'h01;
        default: return 8'h00;
      endcase
    end
    return 8'($urandom);
  endfunction

  // Stimulus
  initial begin
    int unsigned                   taken;
    logic [ps2mpt_pkg::BYTE_W-1:0] st;
    logic [ps2mpt_pkg::BYTE_W-1:0] db;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= '0;
    cfg_wdata_i        <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.ctrl_status <= '0;
    in_bus.data_byte   <= '0;
    load_script();
    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        drain_block();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer_word(script[i].status, script[i].data, script[i].typed, script[i].want);
      end
    end

    // random phases, each on its own screen size
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_block();
      write_reg(ps2mpt_pkg::REG_SCREEN_WIDTH, pick_size());
      write_reg(ps2mpt_pkg::REG_SCREEN_HEIGHT, pick_size());
      calm = (phase == 2);
      if (phase == 5) hold_req = 1'b1;
      taken = 0;
      while (taken < PHASE_WORDS) begin
        if ($urandom_range(99) < 15) begin
          // noise: random status, may or may not be taken
          st = 8'($urandom);
          db = 8'($urandom);
          offer_word(st, db, 1'b0, '0);
          if ((st & ps2mpt_pkg::STATUS_NEED) == ps2mpt_pkg::STATUS_NEED) taken++;
        end else begin
          // well-formed packet with random content
          db = 8'($urandom);
          db[ps2mpt_pkg::BIT_SYNC] = ($urandom_range(99) < 85);
          offer_word(8'($urandom) | ps2mpt_pkg::STATUS_NEED, db, 1'b0, '0);
          offer_word(8'($urandom) | ps2mpt_pkg::STATUS_NEED, pick_delta(), 1'b0, '0);
          offer_word(8'($urandom) | ps2mpt_pkg::STATUS_NEED, pick_delta(), 1'b0, '0);
          taken += 3;
        end
      end
    end
    calm = 1'b0;

    drain_block();
    if (expected_words.size() != 0) note_mismatch("results still expected at end of run");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold, and the compare
  always @(posedge clk_i) begin : result_side
    mouse_word_t got;
    mouse_word_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = {out_bus.cursor_x, out_bus.cursor_y, out_bus.btn_left, out_bus.btn_right,
             out_bus.btn_middle, out_bus.moved, out_bus.redraw};
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
      end else begin
        want = expected_words.pop_front();
        check_field("cursor_x", got.cur_x, want.cur_x);
        check_field("cursor_y", got.cur_y, want.cur_y);
        check_field("btn_left", got.left, want.left);
        check_field("btn_right", got.right, want.right);
        check_field("btn_middle", got.middle, want.middle);
        check_field("moved", got.moved, want.moved);
        check_field("redraw", got.redraw, want.redraw);
      end
      words_seen++;
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ps2mpt_pkg.sv
rtl/ps2mpt_in_if.sv
rtl/ps2mpt_out_if.sv
rtl/ps2_mouse_packet_tracker.sv
tb/ps2_mouse_packet_tracker_test.sv
